// ===== hw/rtl/dcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram CRC package
// Mode codes, reflected polynomials and the byte-wide CRC update shared by
// the engine and its length-prefix unit.
// ----------------------------------------------------------------------------
package dcrc_pkg;

   localparam logic [1:0] MODE_CRC16  = 2'd0;
   localparam logic [1:0] MODE_CRC32  = 2'd1;
   localparam logic [1:0] MODE_CRC32C = 2'd2;
   localparam logic [1:0] MODE_BAD    = 2'd3;

   localparam logic [31:0] POLY16_REFL  = 32'h0000_A001;
   localparam logic [31:0] POLY32_REFL  = 32'hEDB8_8320;
   localparam logic [31:0] POLY32C_REFL = 32'h82F6_3B78;

   localparam logic [31:0] MASK16 = 32'h0000_FFFF;
   localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;
   localparam logic [31:0] INIT16 = 32'h0000_0000;
   localparam logic [31:0] INIT32 = 32'hFFFF_FFFF;

   typedef logic [31:0] crc_type;

   function automatic crc_type mode_poly(input logic [1:0] mode);
      crc_type poly;
      unique case (mode)
         MODE_CRC16:  poly = POLY16_REFL;
         MODE_CRC32:  poly = POLY32_REFL;
         MODE_CRC32C: poly = POLY32C_REFL;
         default:     poly = '0;
      endcase
      return poly;
   endfunction

   function automatic crc_type crc_feed_byte(input crc_type crc, input logic [7:0] data,
                                             input crc_type poly);
      crc_type c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/dcrc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram CRC channels
// Valid/ready channels for message bytes and for checksum results.
// ----------------------------------------------------------------------------
interface dcrc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   logic [30:0] msg_length;

   modport source (output valid, output data_byte, output first_byte,
                   output last_byte, output msg_length, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input last_byte, input msg_length, output ready);
endinterface

interface dcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] checksum;
   logic        bad_mode;

   modport source (output valid, output checksum, output bad_mode, input ready);
   modport sink   (input valid, input checksum, input bad_mode, output ready);
endinterface

// ===== hw/rtl/dcrc_prefix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram CRC length prefix
// CRC of the four little-endian length bytes, started from the mode's init.
// ----------------------------------------------------------------------------
module dcrc_prefix
   import dcrc_pkg::*;
(
   input  logic [30:0] msg_length,
   input  logic [1:0]  crc_mode,
   output crc_type     prefix_crc
);

   logic [31:0] len_word;
   crc_type     init;
   crc_type     poly;
   crc_type     c0;
   crc_type     c1;
   crc_type     c2;
   crc_type     c3;

   assign len_word = {1'b0, msg_length};
   assign poly     = mode_poly(crc_mode);

   always_comb begin
      unique case (crc_mode)
         MODE_CRC16:  init = INIT16;
         MODE_CRC32:  init = INIT32;
         MODE_CRC32C: init = INIT32;
         default:     init = '0;
      endcase
   end

   assign c0 = crc_feed_byte(init, len_word[7:0], poly);
   assign c1 = crc_feed_byte(c0, len_word[15:8], poly);
   assign c2 = crc_feed_byte(c1, len_word[23:16], poly);
   assign c3 = crc_feed_byte(c2, len_word[31:24], poly);

   assign prefix_crc = c3;

endmodule

// ===== hw/rtl/datagram_crc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram CRC engine
// Length-prefixed CRC-16/ARC, CRC-32 or CRC-32C over a byte stream.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word
//  req_chan   in         data_byte, first_byte, last_byte, msg_length
//  rsp_chan   out        checksum, bad_mode (one word per last byte)
//  csr_wr_*   in         crc_mode
//
// One word is taken every cycle unless the pipeline is held. Bytes are
// registered in s1, results in the output register. The rate is set by the
// running CRC register, which takes a one-byte update per cycle (five bytes
// on a first byte, the length prefix being worked out as the word is taken).
// Reset clears the mode to CRC-32 and the running CRC to zero. A stalled
// result holds the pipeline only when the byte behind it is a last byte.
module datagram_crc_engine
   import dcrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dcrc_req_if.sink   req_chan,
   dcrc_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   logic [1:0] crc_mode_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_data_ff;
   logic       s1_first_ff;
   logic       s1_last_ff;
   crc_type    s1_prefix_ff;

   crc_type    crc_running_ff;
   crc_type    crc_running_in;

   logic       out_valid_ff;
   logic       out_valid_in;
   crc_type    out_checksum_ff;
   logic       out_bad_ff;

   crc_type    prefix_crc;
   crc_type    base_crc;
   crc_type    fed_crc;
   crc_type    mask;
   crc_type    xorout;
   logic       mode_bad;
   logic       s1_go;
   logic       take;

   dcrc_prefix u_prefix (
      .msg_length (req_chan.msg_length),
      .crc_mode   (crc_mode_ff),
      .prefix_crc (prefix_crc)
   );

   assign s1_go = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign take = req_chan.valid && req_chan.ready;

   assign mode_bad = (crc_mode_ff == MODE_BAD);

   always_comb begin
      unique case (crc_mode_ff)
         MODE_CRC16:  begin mask = MASK16; xorout = '0;     end
         MODE_CRC32:  begin mask = MASK32; xorout = INIT32; end
         MODE_CRC32C: begin mask = MASK32; xorout = INIT32; end
         default:     begin mask = '0;     xorout = '0;     end
      endcase
   end

   assign base_crc = s1_first_ff ? s1_prefix_ff : crc_running_ff;
   assign fed_crc  = crc_feed_byte(base_crc, s1_data_ff, mode_poly(crc_mode_ff)) & mask;

   assign crc_running_in = (s1_go && !mode_bad) ? fed_crc : crc_running_ff;

   always_comb begin
      if (s1_go && s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_mode_ff    <= MODE_CRC32;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         crc_running_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            crc_mode_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         out_valid_ff   <= out_valid_in;
         crc_running_ff <= crc_running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_data_ff   <= req_chan.data_byte;
         s1_first_ff  <= req_chan.first_byte;
         s1_last_ff   <= req_chan.last_byte;
         s1_prefix_ff <= prefix_crc;
      end
      if (s1_go && s1_last_ff) begin
         out_checksum_ff <= mode_bad ? '0 : ((fed_crc ^ xorout) & mask);
         out_bad_ff      <= mode_bad;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.checksum = out_checksum_ff;
   assign rsp_chan.bad_mode = out_bad_ff;

endmodule

// ===== dv/datagram_crc_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram CRC engine testbench
// Streams message bytes into the engine under every CRC mode and compares
// each returned checksum word against a bit-serial CRC predictor that feeds
// the little-endian length prefix on every first byte. Directed messages
// cover the field extremes and the corner cases. Random messages then run
// under several sender and receiver idling mixes, mostly well formed with
// some broken flag sequences mixed in.
// ----------------------------------------------------------------------------
module datagram_crc_engine_tb
   import dcrc_pkg::*;
();

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [30:0] msg_length;
   } msg_word_type;

   typedef struct packed {
      logic [31:0] checksum;
      logic        bad_mode;
   } crc_result_type;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 4;

   localparam logic [31:0] ARC_REFL  = 32'h0000_A001;
   localparam logic [31:0] ETH_REFL  = 32'hEDB8_8320;
   localparam logic [31:0] CAST_REFL = 32'h82F6_3B78;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   dcrc_req_if req_chan ();
   dcrc_rsp_if rsp_chan ();

   msg_word_type   pending_words[$];
   crc_result_type expected_results[$];
   msg_word_type   next_word;

   logic [1:0]  mode_model;
   logic [31:0] crc_model;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned mismatches    = 0;
   int unsigned quiet_cycles  = 0;

   logic [1:0]  mode_order [4] = '{MODE_CRC16, MODE_CRC32, MODE_CRC32C, MODE_BAD};
   int unsigned send_pcts  [4] = '{0, 55, 0, 30};
   int unsigned stall_pcts [4] = '{0, 0, 55, 30};

   datagram_crc_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc,
                                                  input logic [7:0] value,
                                                  input logic [31:0] poly);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ value[i];
         c  = (c >> 1) ^ (fb ? poly : 32'd0);
      end
      return c;
   endfunction

   function automatic void predict_checksum(input msg_word_type w);
      logic [31:0] poly;
      logic [31:0] seed;
      logic [31:0] xorout;
      logic [31:0] keep;
      logic [31:0] c;
      logic [31:0] len;
      crc_result_type r;
      if (mode_model == MODE_BAD) begin
         if (w.last_byte) begin
            r.checksum = '0;
            r.bad_mode = 1'b1;
            expected_results.push_back(r);
         end
         return;
      end
      case (mode_model)
         MODE_CRC16: begin
            poly = ARC_REFL;  seed = 32'h0;        xorout = 32'h0;        keep = 32'h0000_FFFF;
         end
         MODE_CRC32: begin
            poly = ETH_REFL;  seed = 32'hFFFF_FFFF; xorout = 32'hFFFF_FFFF; keep = 32'hFFFF_FFFF;
         end
         default: begin
            poly = CAST_REFL; seed = 32'hFFFF_FFFF; xorout = 32'hFFFF_FFFF; keep = 32'hFFFF_FFFF;
         end
      endcase
      c = crc_model;
      if (w.first_byte) begin
         len = {1'b0, w.msg_length};
         c = seed;
         for (int i = 0; i < 4; i++) begin
            c = crc_shift_byte(c, len[8*i +: 8], poly);
         end
      end
      c = crc_shift_byte(c, w.data_byte, poly) & keep;
      crc_model = c;
      if (w.last_byte) begin
         r.checksum = (c ^ xorout) & keep;
         r.bad_mode = 1'b0;
         expected_results.push_back(r);
      end
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode_model = MODE_CRC32;
         crc_model  = '0;
         req_chan.valid <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_model = csr_wr_data;
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_checksum({req_chan.data_byte, req_chan.first_byte,
                              req_chan.last_byte, req_chan.msg_length});
         end
         if (req_chan.valid && !req_chan.ready) begin
            req_chan.valid <= 1'b1;
         end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = pending_words.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.data_byte  <= next_word.data_byte;
            req_chan.first_byte <= next_word.first_byte;
            req_chan.last_byte  <= next_word.last_byte;
            req_chan.msg_length <= next_word.msg_length;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word checksum %h bad_mode %b",
                                      rsp_chan.checksum, rsp_chan.bad_mode));
         end else if (rsp_chan.checksum !== expected_results[0].checksum ||
                      rsp_chan.bad_mode !== expected_results[0].bad_mode) begin
            report_mismatch($sformatf("checksum exp %h got %h, bad_mode exp %b got %b",
                                      expected_results[0].checksum, rsp_chan.checksum,
                                      expected_results[0].bad_mode, rsp_chan.bad_mode));
            void'(expected_results.pop_front());
         end else begin
            void'(expected_results.pop_front());
         end
      end
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      quiet_cycles <= ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
                      ? 0 : quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   function automatic void push_word(input logic [7:0] data, input bit first, input bit last,
                                     input logic [30:0] len);
      msg_word_type w;
      w.data_byte  = data;
      w.first_byte = first;
      w.last_byte  = last;
      w.msg_length = len;
      pending_words.push_back(w);
   endfunction

   function automatic void queue_random_bytes(input int unsigned count);
      int unsigned queued;
      int unsigned nbytes;
      logic [30:0] len;
      bit          tidy;
      queued = 0;
      while (queued < count) begin
         nbytes = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         tidy   = ($urandom_range(9) != 0);
         len    = ($urandom_range(2) == 0) ? 31'($urandom_range(32'h7FFF_FFFF, 1))
                                           : 31'(nbytes);
         for (int i = 0; i < nbytes; i++) begin
            if (tidy) begin
               push_word(8'($urandom), i == 0, i == nbytes - 1,
                         (i == 0) ? len : 31'($urandom_range(32'h7FFF_FFFF, 1)));
            end else begin
               push_word(8'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0,
                         31'($urandom_range(32'h7FFF_FFFF, 1)));
            end
         end
         queued += nbytes;
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_chan.valid || expected_results.size() != 0);
   endtask

   task automatic set_crc_mode(input logic [1:0] mode);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = MODE_CRC16;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.first_byte = 1'b0;
      req_chan.last_byte  = 1'b0;
      req_chan.msg_length = '0;
      rsp_chan.ready      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Bytes ahead of any first byte continue from the cleared register.
      push_word(8'h00, 1'b0, 1'b0, 31'd1);
      push_word(8'hFF, 1'b0, 1'b1, 31'h7FFF_FFFF);
      push_word(8'hFF, 1'b1, 1'b1, 31'h7FFF_FFFF);
      push_word(8'h00, 1'b1, 1'b1, 31'd1);
      push_word(8'h80, 1'b1, 1'b0, 31'd3);
      push_word(8'h01, 1'b0, 1'b0, 31'd1);
      push_word(8'h7F, 1'b0, 1'b1, 31'd1);
      push_word(8'h5A, 1'b1, 1'b0, 31'd3);
      // The open message is held through the unsupported mode and closed under CRC-16.
      set_crc_mode(MODE_BAD);
      push_word(8'hC3, 1'b0, 1'b0, 31'd1);
      push_word(8'h11, 1'b1, 1'b1, 31'h7FFF_FFFF);
      set_crc_mode(MODE_CRC16);
      push_word(8'h3C, 1'b0, 1'b1, 31'd1);
      push_word(8'hA5, 1'b1, 1'b1, 31'd1);
      push_word(8'hFF, 1'b1, 1'b0, 31'h7FFF_FFFF);
      push_word(8'h00, 1'b0, 1'b1, 31'd1);
      set_crc_mode(MODE_CRC32C);
      push_word(8'hFF, 1'b1, 1'b1, 31'h7FFF_FFFF);
      push_word(8'h00, 1'b1, 1'b0, 31'd2);
      push_word(8'hE7, 1'b0, 1'b1, 31'd1);

      for (int p = 0; p < 8; p++) begin
         set_crc_mode(mode_order[p % 4]);
         @(negedge clock);
         send_idle_pct = send_pcts[(p / 2) % 4];
         stall_pct     = stall_pcts[(p / 2) % 4];
         queue_random_bytes(70);
         wait_drained();
         queue_random_bytes(70);
      end

      wait_drained();
      repeat (SETTLE_CYCLES + 2) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
